@@ rtl/lid_pkg.sv @@
// Shared types and constants for the line intersection detector.
package lid_pkg;

   localparam int SENSOR_COUNT = 6;
   localparam int STAMP_W      = 32;
   localparam int CFG_W        = 16;
   localparam int RUN_W        = 16;
   localparam int CSR_IDX_W    = 2;

   // sensor positions within the sensor vector
   localparam int SNS_FAR_LEFT  = 0;
   localparam int SNS_LEFT      = 1;
   localparam int SNS_MID_LEFT  = 2;
   localparam int SNS_CENTER    = 3;
   localparam int SNS_MID_RIGHT = 4;
   localparam int SNS_RIGHT     = 5;

   localparam logic [RUN_W-1:0] RUN_MAX = '1;

   typedef enum logic {
      CMD_SAMPLE  = 1'b0,
      CMD_CONSUME = 1'b1
   } cmd_type;

   localparam logic [1:0] DET_NONE  = 2'd0;
   localparam logic [1:0] DET_CROSS = 2'd1;
   localparam logic [1:0] DET_LEFTT = 2'd2;
   localparam logic [1:0] DET_TURN  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_CROSS_WINDOW   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STABLE_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_TIMEOUT = 2'd2;

   localparam logic [CFG_W-1:0] CROSS_WINDOW_RST   = 16'd200;
   localparam logic [CFG_W-1:0] STABLE_COUNT_RST   = 16'd3;
   localparam logic [CFG_W-1:0] ACTIVE_TIMEOUT_RST = 16'd500;

   typedef struct packed {
      logic [CFG_W-1:0] cross_window;
      logic [CFG_W-1:0] stable_count;
      logic [CFG_W-1:0] active_timeout;
   } cfg_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [SENSOR_COUNT-1:0] sensors;
      logic [STAMP_W-1:0]      now_ms;
   } item_type;

   typedef struct packed {
      logic [1:0] detection;
      logic       cross_pending;
      logic       left_t_pending;
      logic       turn_pending;
   } result_type;

endpackage

@@ rtl/lid_csr.sv @@
// Configuration registers of the line intersection detector.
module lid_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lid_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lid_pkg::CFG_W-1:0]        csr_wdata,
   output lid_pkg::cfg_type                 cfg
);
   import lid_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index)
            CSR_CROSS_WINDOW:   cfg_in.cross_window   = csr_wdata;
            CSR_STABLE_COUNT:   cfg_in.stable_count   = csr_wdata;
            CSR_ACTIVE_TIMEOUT: cfg_in.active_timeout = csr_wdata;
            default:            cfg_in = cfg_ff;  // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cross_window   <= CROSS_WINDOW_RST;
         cfg_ff.stable_count   <= STABLE_COUNT_RST;
         cfg_ff.active_timeout <= ACTIVE_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/lid_core.sv @@
// Detection state and the single-pass update for one sample or consume item.
module lid_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  lid_pkg::item_type   item,
   input  lid_pkg::cfg_type    cfg,
   output lid_pkg::result_type result
);
   import lid_pkg::*;

   logic [STAMP_W-1:0] stamp_ff [SENSOR_COUNT];
   logic [STAMP_W-1:0] stamp_in [SENSOR_COUNT];
   logic [RUN_W-1:0]   lt_run_ff, lt_run_in;
   logic [RUN_W-1:0]   act_run_ff, act_run_in;
   logic               cross_ff, cross_in;
   logic               left_t_ff, left_t_in;
   logic               armed_ff, armed_in;
   logic               turn_ff, turn_in;
   logic [STAMP_W-1:0] armed_stamp_ff, armed_stamp_in;

   // sample-path helpers
   logic [STAMP_W-1:0]      stamp_upd [SENSOR_COUNT];
   logic [SENSOR_COUNT-1:0] in_win;
   logic [STAMP_W-1:0]      now;
   logic [SENSOR_COUNT-1:0] s;
   logic                    pat_left_t, pat_all_act, all_off, center_only;
   logic [RUN_W-1:0]        lt_run_nx, act_run_nx;
   logic                    cross_set;
   logic [STAMP_W-1:0]      right_stamp;
   logic [STAMP_W-1:0]      arm_age;
   logic [1:0]              det;

   assign now = item.now_ms;
   assign s   = item.sensors;

   assign pat_left_t  = s[SNS_FAR_LEFT] && s[SNS_LEFT] && s[SNS_MID_LEFT] &&
                        s[SNS_CENTER] && !s[SNS_MID_RIGHT] && !s[SNS_RIGHT];
   assign pat_all_act = s[SNS_LEFT] && s[SNS_MID_LEFT] && s[SNS_CENTER] &&
                        s[SNS_MID_RIGHT] && s[SNS_RIGHT];
   assign all_off     = (s == '0);
   assign center_only = (s[SNS_MID_LEFT] || s[SNS_CENTER] || s[SNS_MID_RIGHT]) &&
                        !s[SNS_FAR_LEFT] && !s[SNS_LEFT] && !s[SNS_RIGHT];

   // saturating run counters
   assign lt_run_nx  = !pat_left_t  ? '0 :
                       (lt_run_ff == RUN_MAX)  ? lt_run_ff  : lt_run_ff + 1'b1;
   assign act_run_nx = !pat_all_act ? '0 :
                       (act_run_ff == RUN_MAX) ? act_run_ff : act_run_ff + 1'b1;

   // six window checks in parallel; a zero stamp means never seen
   always_comb begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         stamp_upd[i] = s[i] ? now : stamp_ff[i];
         in_win[i]    = (stamp_upd[i] != '0) &&
                        ((now - stamp_upd[i]) <= {{(STAMP_W-CFG_W){1'b0}}, cfg.cross_window});
      end
   end

   assign cross_set   = !cross_ff && (&in_win) && center_only;
   assign right_stamp = cross_set ? '0 : stamp_upd[SNS_RIGHT];
   assign arm_age     = now - armed_stamp_ff;

   always_comb begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         stamp_in[i] = stamp_ff[i];
      end
      lt_run_in      = lt_run_ff;
      act_run_in     = act_run_ff;
      cross_in       = cross_ff;
      left_t_in      = left_t_ff;
      armed_in       = armed_ff;
      turn_in        = turn_ff;
      armed_stamp_in = armed_stamp_ff;
      det            = DET_NONE;

      if (step_en) begin
         case (item.cmd)
            CMD_SAMPLE: begin
               lt_run_in  = lt_run_nx;
               act_run_in = act_run_nx;
               for (int i = 0; i < SENSOR_COUNT; i++) begin
                  stamp_in[i] = cross_set ? '0 : stamp_upd[i];
               end
               cross_in = cross_ff || cross_set;
               if (!left_t_ff && (lt_run_nx >= cfg.stable_count) &&
                   (right_stamp <= {{(STAMP_W-CFG_W){1'b0}}, cfg.cross_window})) begin
                  left_t_in = 1'b1;
               end
               if (!cross_in && !left_t_in && (act_run_nx >= cfg.stable_count)) begin
                  armed_in       = 1'b1;
                  armed_stamp_in = now;
               end else if (armed_ff) begin
                  if (arm_age > {{(STAMP_W-CFG_W){1'b0}}, cfg.active_timeout}) begin
                     armed_in   = 1'b0;
                     act_run_in = '0;
                  end else if (all_off) begin
                     turn_in    = 1'b1;
                     armed_in   = 1'b0;
                     act_run_in = '0;
                  end
               end
            end
            CMD_CONSUME: begin
               if (cross_ff) begin
                  cross_in = 1'b0;
                  det      = DET_CROSS;
               end else if (left_t_ff) begin
                  left_t_in = 1'b0;
                  lt_run_in = '0;
                  det       = DET_LEFTT;
               end else if (turn_ff) begin
                  turn_in    = 1'b0;
                  armed_in   = 1'b0;
                  act_run_in = '0;
                  det        = DET_TURN;
               end
            end
            default: det = DET_NONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            stamp_ff[i] <= '0;
         end
         lt_run_ff      <= '0;
         act_run_ff     <= '0;
         cross_ff       <= 1'b0;
         left_t_ff      <= 1'b0;
         armed_ff       <= 1'b0;
         turn_ff        <= 1'b0;
         armed_stamp_ff <= '0;
      end else begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            stamp_ff[i] <= stamp_in[i];
         end
         lt_run_ff      <= lt_run_in;
         act_run_ff     <= act_run_in;
         cross_ff       <= cross_in;
         left_t_ff      <= left_t_in;
         armed_ff       <= armed_in;
         turn_ff        <= turn_in;
         armed_stamp_ff <= armed_stamp_in;
      end
   end

   assign result.detection      = det;
   assign result.cross_pending  = cross_in;
   assign result.left_t_pending = left_t_in;
   assign result.turn_pending   = turn_in;

endmodule

@@ rtl/line_intersection_detector.sv @@
// Top level of the line intersection detector: channel registers around the core.
//
// Usage:
//   req_* carries one item per handshake: cmd 0 is a sensor sample (six line
//   bits plus now_ms), cmd 1 consumes the highest-priority pending detection.
//   An item is taken at an edge with req_valid high and req_stall low.
//   rsp_* returns exactly one result item per request item, in order:
//   detection code (consume only) and the three pending flags after the step.
//   csr_* writes cross_window_ms (0), stable_count (1), active_timeout_ms (2);
//   csr_ready is always high. Write only while no item is in flight.
// Data path / throughput:
//   An accepted item is held in the input register; the core updates its
//   state at the same edge that loads its result into the result register,
//   which drives rsp_*. One item per cycle is sustained while rsp_stall
//   stays low.
// Reset (synchronous, active high): clears all stamps, counters and flags,
//   loads the config defaults (200, 3, 500) and empties both registers.
// Receiver stall: the result register holds; the input register still drains
//   into an empty result slot, so one further item can be taken before
//   req_stall rises.
module line_intersection_detector (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic                          req_far_left,
   input  logic                          req_left_bit,
   input  logic                          req_mid_left,
   input  logic                          req_center_bit,
   input  logic                          req_mid_right,
   input  logic                          req_right_bit,
   input  logic [lid_pkg::STAMP_W-1:0]   req_now_ms,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_detection,
   output logic                          rsp_cross_pending,
   output logic                          rsp_left_t_pending,
   output logic                          rsp_turn_pending,
   // config write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lid_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lid_pkg::CFG_W-1:0]     csr_wdata
);
   import lid_pkg::*;

   cfg_type    cfg;
   item_type   req_item;
   item_type   in_item_ff;
   logic       in_vld_ff, in_vld_in;
   result_type core_res;
   result_type out_res_ff;
   logic       out_vld_ff, out_vld_in;
   logic       accept, advance;

   assign req_item.cmd     = cmd_type'(req_cmd);
   assign req_item.sensors = {req_right_bit, req_mid_right, req_center_bit,
                              req_mid_left, req_left_bit, req_far_left};
   assign req_item.now_ms  = req_now_ms;

   // item moves from input reg into result reg when the result slot frees
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_vld_in  = accept || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_res_ff <= core_res;
      end
   end

   lid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lid_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (core_res)
   );

   assign rsp_valid          = out_vld_ff;
   assign rsp_detection      = out_res_ff.detection;
   assign rsp_cross_pending  = out_res_ff.cross_pending;
   assign rsp_left_t_pending = out_res_ff.left_t_pending;
   assign rsp_turn_pending   = out_res_ff.turn_pending;

endmodule

@@ bench/lid_scoreboard_pkg.sv @@
// Scoreboard for the line intersection detector bench: state predictor and result checker.
package lid_scoreboard_pkg;
   import lid_pkg::*;

   class detection_scoreboard;
      cfg_type            cfg;
      logic [STAMP_W-1:0] seen_at [SENSOR_COUNT];
      logic [RUN_W-1:0]   left_t_run;
      logic [RUN_W-1:0]   active_run;
      bit                 cross_f;
      bit                 left_t_f;
      bit                 armed_f;
      bit                 turn_f;
      logic [STAMP_W-1:0] armed_at;
      result_type         pending_results[$];
      int                 errors;

      function new();
         cfg = '{CROSS_WINDOW_RST, STABLE_COUNT_RST, ACTIVE_TIMEOUT_RST};
         foreach (seen_at[i]) seen_at[i] = '0;
         left_t_run = '0;
         active_run = '0;
         cross_f    = 1'b0;
         left_t_f   = 1'b0;
         armed_f    = 1'b0;
         turn_f     = 1'b0;
         armed_at   = '0;
         errors     = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         case (idx)
            CSR_CROSS_WINDOW:   cfg.cross_window   = val;
            CSR_STABLE_COUNT:   cfg.stable_count   = val;
            CSR_ACTIVE_TIMEOUT: cfg.active_timeout = val;
            default: ;
         endcase
      endfunction

      // saturating run counter
      function logic [RUN_W-1:0] bump(logic [RUN_W-1:0] run, bit hit);
         if (!hit)
            return '0;
         return (run == RUN_MAX) ? run : run + 1'b1;
      endfunction

      function void take_item(item_type it);
         result_type         res;
         logic [STAMP_W-1:0] age;
         bit                 fl, lt, ml, ct, mr, rt;
         bit                 window_ok;
         res = '0;
         if (it.cmd == CMD_SAMPLE) begin
            fl = it.sensors[SNS_FAR_LEFT];
            lt = it.sensors[SNS_LEFT];
            ml = it.sensors[SNS_MID_LEFT];
            ct = it.sensors[SNS_CENTER];
            mr = it.sensors[SNS_MID_RIGHT];
            rt = it.sensors[SNS_RIGHT];
            left_t_run = bump(left_t_run, fl && lt && ml && ct && !mr && !rt);
            active_run = bump(active_run, lt && ml && ct && mr && rt);
            foreach (seen_at[i]) if (it.sensors[i]) seen_at[i] = it.now_ms;

            if (!cross_f) begin
               window_ok = 1'b1;
               foreach (seen_at[i]) begin
                  age = it.now_ms - seen_at[i];
                  if (seen_at[i] == '0 || age > cfg.cross_window)
                     window_ok = 1'b0;
               end
               if (window_ok && (ml || ct || mr) && !fl && !lt && !rt) begin
                  cross_f = 1'b1;
                  foreach (seen_at[i]) seen_at[i] = '0;
               end
            end

            // raw stamp of the right sensor, not its age
            if (!left_t_f && left_t_run >= cfg.stable_count &&
                seen_at[SNS_RIGHT] <= cfg.cross_window)
               left_t_f = 1'b1;

            if (!cross_f && !left_t_f && active_run >= cfg.stable_count) begin
               armed_f  = 1'b1;
               armed_at = it.now_ms;
            end else if (armed_f) begin
               age = it.now_ms - armed_at;
               if (age > cfg.active_timeout) begin
                  armed_f    = 1'b0;
                  active_run = '0;
               end else if (it.sensors == '0) begin
                  turn_f     = 1'b1;
                  armed_f    = 1'b0;
                  active_run = '0;
               end
            end
         end else if (cross_f) begin
            cross_f       = 1'b0;
            res.detection = DET_CROSS;
         end else if (left_t_f) begin
            left_t_f      = 1'b0;
            left_t_run    = '0;
            res.detection = DET_LEFTT;
         end else if (turn_f) begin
            turn_f        = 1'b0;
            armed_f       = 1'b0;
            active_run    = '0;
            res.detection = DET_TURN;
         end else begin
            res.detection = DET_NONE;
         end
         res.cross_pending  = cross_f;
         res.left_t_pending = left_t_f;
         res.turn_pending   = turn_f;
         pending_results.push_back(res);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            $error("result item arrived with none expected");
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.detection !== want.detection) begin
            $error("detection: expected %0d, got %0d", want.detection, got.detection);
            errors++;
         end
         if (got.cross_pending !== want.cross_pending) begin
            $error("cross_pending: expected %0d, got %0d",
                   want.cross_pending, got.cross_pending);
            errors++;
         end
         if (got.left_t_pending !== want.left_t_pending) begin
            $error("left_t_pending: expected %0d, got %0d",
                   want.left_t_pending, got.left_t_pending);
            errors++;
         end
         if (got.turn_pending !== want.turn_pending) begin
            $error("turn_pending: expected %0d, got %0d",
                   want.turn_pending, got.turn_pending);
            errors++;
         end
      endfunction
   endclass

endpackage

@@ bench/tb_line_intersection_detector.sv @@
// Self-checking bench for the line intersection detector: directed and random items.
module tb_line_intersection_detector;
   import lid_pkg::*;
   import lid_scoreboard_pkg::*;

   // generous: the slowest legal run stays well under a third of this
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_ITEMS = 180;

   // index with no register behind it; writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // sensor patterns
   localparam logic [SENSOR_COUNT-1:0] PAT_ALL       = '1;
   localparam logic [SENSOR_COUNT-1:0] PAT_FAR_LEFT  = 6'(1 << SNS_FAR_LEFT);
   localparam logic [SENSOR_COUNT-1:0] PAT_RIGHT     = 6'(1 << SNS_RIGHT);
   localparam logic [SENSOR_COUNT-1:0] PAT_CENTER    = 6'(1 << SNS_CENTER);
   localparam logic [SENSOR_COUNT-1:0] PAT_ACTIVE    = PAT_ALL ^ PAT_FAR_LEFT;
   localparam logic [SENSOR_COUNT-1:0] PAT_MIDDLE    =
      6'((1 << SNS_MID_LEFT) | (1 << SNS_CENTER) | (1 << SNS_MID_RIGHT));
   localparam logic [SENSOR_COUNT-1:0] PAT_EDGES     =
      6'((1 << SNS_FAR_LEFT) | (1 << SNS_LEFT) | (1 << SNS_RIGHT));
   localparam logic [SENSOR_COUNT-1:0] PAT_LEFT_T    =
      6'((1 << SNS_FAR_LEFT) | (1 << SNS_LEFT) | (1 << SNS_MID_LEFT) | (1 << SNS_CENTER));

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_cmd;
   logic                 req_far_left;
   logic                 req_left_bit;
   logic                 req_mid_left;
   logic                 req_center_bit;
   logic                 req_mid_right;
   logic                 req_right_bit;
   logic [STAMP_W-1:0]   req_now_ms;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_detection;
   logic                 rsp_cross_pending;
   logic                 rsp_left_t_pending;
   logic                 rsp_turn_pending;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   detection_scoreboard  sb;
   logic [STAMP_W-1:0]   stamp_now;    // last time stamp sent
   bit                   send_idle;    // sender inserts gaps
   bit                   sink_idle;    // receiver inserts stalls
   int unsigned          sink_hold;
   int unsigned          sent;
   int unsigned          cycle_count;

   line_intersection_detector i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side: check each accepted item, then draw the stall before the next one.
   // Outputs are read at the edge, before the block's own updates land.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_result({rsp_detection, rsp_cross_pending,
                             rsp_left_t_pending, rsp_turn_pending});
            sink_hold = sink_idle ? $urandom_range(0, 8) : 0;
         end
         if (sink_hold != 0) begin
            rsp_stall <= 1'b1;
            sink_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Drive one item, optionally after a random gap, and hold it until taken.
   // With no gap, valid stays high from the previous item: one assignment per step.
   task automatic send_item(item_type it);
      int unsigned gap;
      gap = send_idle ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= it.cmd;
      req_far_left   <= it.sensors[SNS_FAR_LEFT];
      req_left_bit   <= it.sensors[SNS_LEFT];
      req_mid_left   <= it.sensors[SNS_MID_LEFT];
      req_center_bit <= it.sensors[SNS_CENTER];
      req_mid_right  <= it.sensors[SNS_MID_RIGHT];
      req_right_bit  <= it.sensors[SNS_RIGHT];
      req_now_ms     <= it.now_ms;
      do @(posedge clock); while (req_stall);
      sb.take_item(it);
      sent++;
   endtask

   task automatic put_sample(logic [SENSOR_COUNT-1:0] bits, logic [STAMP_W-1:0] t);
      item_type it;
      stamp_now  = t;
      it.cmd     = CMD_SAMPLE;
      it.sensors = bits;
      it.now_ms  = t;
      send_item(it);
   endtask

   // consume ignores sensors and time, so those carry junk
   task automatic put_consume();
      item_type it;
      it.cmd     = CMD_CONSUME;
      it.sensors = 6'($urandom);
      it.now_ms  = $urandom;
      send_item(it);
   endtask

   // Time step around a limit: hits the exact edge, one past it, and long jumps
   // that toggle the upper stamp bits and wrap the 32-bit clock.
   function automatic logic [STAMP_W-1:0] step_near(int unsigned lim);
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return lim;
         2:       return lim + 1;
         3:       return $urandom;
         default: return $urandom_range(0, lim / 2 + 1);
      endcase
   endfunction

   // Stop sending and wait until every expected result is back, plus pipeline depth.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all registers (and the unused index) back to back; valid stays high throughout.
   task automatic write_regs(cfg_type c);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [CFG_W-1:0]     val [4];
      idx = '{CSR_CROSS_WINDOW, CSR_STABLE_COUNT, CSR_UNUSED, CSR_ACTIVE_TIMEOUT};
      val = '{c.cross_window, c.stable_count, CFG_W'($urandom), c.active_timeout};
      foreach (idx[k]) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         do @(posedge clock); while (!csr_ready);
         sb.set_reg(idx[k], val[k]);
      end
      csr_valid <= 1'b0;
   endtask

   // Random traffic built from short scenarios with random content. Most of them
   // are well-formed attempts at a detection; the rest is noise and consumes.
   task automatic run_phase(int unsigned count);
      int unsigned              stop_at;
      int unsigned              n;
      logic [STAMP_W-1:0]       age;
      logic [STAMP_W-1:0]       armed_time;
      logic [SENSOR_COUNT-1:0]  bits;
      stop_at = sent + count;
      while (sent < stop_at) begin
         // idling on most scenarios, back-to-back on the rest
         send_idle = ($urandom_range(0, 3) != 0);
         sink_idle = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1: begin
               // cross: mostly light everything, then mostly only middle sensors near the window edge
               if ($urandom_range(0, 3) != 0)
                  put_sample(PAT_ALL, stamp_now + $urandom_range(0, 3));
               else
                  repeat ($urandom_range(1, 3))
                     put_sample(6'($urandom), stamp_now + $urandom_range(0, 3));
               bits = 6'($urandom) & PAT_MIDDLE;
               if ($urandom_range(0, 7) == 0)
                  bits |= 6'($urandom) & PAT_EDGES;
               put_sample(bits, stamp_now + step_near(sb.cfg.cross_window));
            end
            2, 3: begin
               // left T: right stamp must be small in raw value, so often
               // jump back to an early time with the right sensor lit
               if ($urandom_range(0, 1))
                  put_sample(6'($urandom) | PAT_RIGHT, $urandom_range(0, sb.cfg.cross_window));
               n = sb.cfg.stable_count + $urandom_range(0, 2);
               n = (n > 1) ? n - 1 : 1;
               repeat (n) begin
                  bits = ($urandom_range(0, 9) == 0) ? 6'($urandom) : PAT_LEFT_T;
                  put_sample(bits, stamp_now + $urandom_range(0, 3));
               end
            end
            4, 5: begin
               // turn: pending cross and left-T flags block arming, so consume a few first
               repeat ($urandom_range(0, 3)) put_consume();
               n = sb.cfg.stable_count + $urandom_range(0, 2);
               if (n == 0)
                  n = 1;
               repeat (n)
                  put_sample(PAT_ACTIVE | (6'($urandom) & PAT_FAR_LEFT),
                             stamp_now + $urandom_range(0, 3));
               armed_time = stamp_now;
               repeat ($urandom_range(0, 2))
                  put_sample(6'($urandom), stamp_now + $urandom_range(0, 3));
               // all-off around the timeout edge, measured from the last arm
               age = step_near(sb.cfg.active_timeout);
               if (age < stamp_now - armed_time)
                  age = stamp_now - armed_time;
               bits = ($urandom_range(0, 4) == 0) ? 6'($urandom) : '0;
               put_sample(bits, armed_time + age);
            end
            6, 7: begin
               repeat ($urandom_range(1, 4))
                  put_sample(6'($urandom), stamp_now + step_near(sb.cfg.cross_window));
            end
            8: begin
               repeat ($urandom_range(1, 2)) put_consume();
            end
            default: begin
               // sender holds off until the block has drained
               put_consume();
               wait_idle();
            end
         endcase
      end
   endtask

   initial begin
      cfg_type plan [6];
      int      k;

      sb = new();
      stamp_now = '0;
      sent      = 0;
      send_idle = 1'b1;
      sink_idle = 1'b1;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_cmd        <= CMD_SAMPLE;
      req_far_left   <= 1'b0;
      req_left_bit   <= 1'b0;
      req_mid_left   <= 1'b0;
      req_center_bit <= 1'b0;
      req_mid_right  <= 1'b0;
      req_right_bit  <= 1'b0;
      req_now_ms     <= '0;
      rsp_stall      <= 1'b0;
      csr_valid      <= 1'b0;
      csr_index      <= CSR_CROSS_WINDOW;
      csr_wdata      <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed, reset defaults: window 200, stable 3, timeout 500 ----
      put_consume();                          // nothing pending
      put_sample(PAT_ALL, 32'd0);             // stamps of 0 read as never seen
      put_sample(PAT_CENTER, 32'd10);         // so no cross here
      put_sample(PAT_LEFT_T, 32'd20);         // left T: right stamp still 0
      put_sample(PAT_LEFT_T, 32'd21);
      put_sample(PAT_LEFT_T, 32'd22);
      put_sample(PAT_ALL, 32'd100);
      put_sample(PAT_CENTER, 32'd300);        // age exactly the window: cross
      put_consume();                          // cross first
      put_consume();                          // then left T
      put_consume();                          // then nothing
      put_sample(PAT_ACTIVE, 32'd400);
      put_sample(PAT_ACTIVE, 32'd401);
      put_sample(PAT_ACTIVE, 32'd402);        // armed
      put_sample('0, 32'd902);                // age equals timeout: turn fires
      put_consume();
      put_sample(PAT_ACTIVE, 32'd1000);
      put_sample(PAT_ACTIVE, 32'd1001);
      put_sample(PAT_ACTIVE, 32'd1002);
      put_sample('0, 32'd1503);               // one past timeout: arm dropped
      put_sample(PAT_ALL, 32'd2000);
      put_sample(PAT_CENTER, 32'd2201);       // one past window: no cross
      put_sample(PAT_ALL, 32'hFFFF_FFF0);
      put_sample(PAT_CENTER, 32'h0000_0010);  // age across the 32-bit wrap
      put_consume();
      put_sample(PAT_ALL, 32'hFFFF_FFFF);

      // ---- random phases over several settings, extremes included ----
      plan = '{'{16'd200,   16'd3, 16'd500},
               '{16'd0,     16'd1, 16'd0},
               '{16'hFFFF,  16'd2, 16'hFFFF},
               '{16'd40,    16'd0, 16'd60},     // stable count of zero
               '{16'd1000,  16'd4, 16'd300},
               '{CFG_W'($urandom_range(1, 3000)), CFG_W'($urandom_range(1, 4)),
                 CFG_W'($urandom_range(1, 3000))}};
      for (k = 0; k < 6; k++) begin
         wait_idle();
         write_regs(plan[k]);
         run_phase(PHASE_ITEMS);
      end

      wait_idle();
      if (sb.errors == 0 && sb.pending_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
